FILE: rtl/sqrtn_pkg.sv
// Shared types, constants and seed functions for the Newton square root core.
package sqrtn_pkg;

    localparam int RAD_W          = 48;
    localparam int ROOT_W         = 32;
    localparam int TOL_W          = 16;
    localparam int FRAC_BITS      = 16;
    localparam int NUM_W          = 64;
    localparam int MAX_ITERATIONS = 64;
    localparam int STEP_CNT_W     = 8;
    localparam int DIV_STEPS      = NUM_W;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
    localparam int K_MAX          = 6;
    localparam int K_W            = $clog2(K_MAX + 1);

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    // 100^(j+1) in Q31.16 units, j = 0 .. K_MAX-1
    localparam logic [NUM_W-1:0] BOUNDS [K_MAX] = '{
        64'd6553600,
        64'd655360000,
        64'd65536000000,
        64'd6553600000000,
        64'd655360000000000,
        64'd65536000000000000
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_STEP,
        S_CHECK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load_in;
        logic div_init;
        logic div_step;
        logic step_x;
        logic out_load;
        logic out_hit;
    } t_cmd;

    typedef struct packed {
        logic special;   // negative or zero radicand, no iteration
        logic settled;   // last two values within tolerance, or value hit zero
    } t_status;

    // Least k with radicand <= 100^(k+1), capped at K_MAX
    function automatic logic [K_W-1:0] decade_count(input logic [NUM_W-1:0] rad);
        logic [K_W-1:0] cnt;
        cnt = '0;
        for (int j = 0; j < K_MAX; j++) begin
            if (rad > BOUNDS[j]) begin
                cnt = cnt + K_W'(1);
            end
        end
        return cnt;
    endfunction

    // Start value 7 * 10^k in Q48.16
    function automatic logic [NUM_W-1:0] seed_value(input logic [K_W-1:0] k);
        logic [NUM_W-1:0] v;
        unique case (k)
            K_W'(0): v = 64'd458752;
            K_W'(1): v = 64'd4587520;
            K_W'(2): v = 64'd45875200;
            K_W'(3): v = 64'd458752000;
            K_W'(4): v = 64'd4587520000;
            K_W'(5): v = 64'd45875200000;
            default: v = 64'd458752000000;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/square_root_newton_core.sv
// Top level: Newton square root of a signed Q31.16 radicand into unsigned Q16.16.
// Negative or zero radicand: no iteration. Otherwise n Newton steps run, n from 1 to 64,
// each a bit-serial division plus update and check. One item at a time; the next
// item is taken once the current one is in the output register, even while that result waits.
// Reset (synchronous, active low) idles the controller, drops o_valid, sets tolerance to 1.
module square_root_newton_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [sqrtn_pkg::RAD_W-1:0]  i_radicand,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [sqrtn_pkg::ROOT_W-1:0]        o_root,
    output logic                                o_negative_error,
    output logic                                o_hit_limit,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sqrtn_pkg::TOL_W-1:0]         i_cfg_data
);
    import sqrtn_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    sqrtn_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (cmd),
        .i_status (status)
    );

    sqrtn_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_radicand       (i_radicand),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .o_root           (o_root),
        .o_negative_error (o_negative_error),
        .o_hit_limit      (o_hit_limit)
    );

endmodule

FILE: rtl/sqrtn_datapath.sv
// Datapath: radicand capture, bit-serial divider, Newton update, tolerance check, result register.
module sqrtn_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sqrtn_pkg::t_cmd                 i_cmd,
    output sqrtn_pkg::t_status              o_status,
    input  logic signed [sqrtn_pkg::RAD_W-1:0] i_radicand,
    input  logic                            i_cfg_valid,
    input  logic [sqrtn_pkg::TOL_W-1:0]     i_cfg_data,
    output logic [sqrtn_pkg::ROOT_W-1:0]    o_root,
    output logic                            o_negative_error,
    output logic                            o_hit_limit
);
    import sqrtn_pkg::*;

    logic [TOL_W-1:0]  r_tol;
    logic [NUM_W-1:0]  r_num, r_x, r_prev, r_quo, r_rem;
    logic              r_neg, r_zero;
    logic [ROOT_W-1:0] r_root;
    logic              r_neg_out, r_hit_out;

    logic [NUM_W-1:0] rad_ext;
    logic [NUM_W:0]   rem_sh, rem_sub;
    logic             q_bit;
    logic [NUM_W-1:0] n_rem, n_x, abs_diff;
    logic [ROOT_W-1:0] root_sat;

    assign rad_ext = {{(NUM_W-RAD_W){1'b0}}, $unsigned(i_radicand)};

    // one restoring division step per cycle, dividend shifts out of r_quo
    assign rem_sh  = {r_rem, r_quo[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_x};
    assign q_bit   = ~rem_sub[NUM_W];
    assign n_rem   = q_bit ? rem_sub[NUM_W-1:0] : rem_sh[NUM_W-1:0];

    // floor((x + q) / 2) without a carry out
    assign n_x = (r_x >> 1) + (r_quo >> 1) + {{(NUM_W-1){1'b0}}, r_x[0] & r_quo[0]};

    assign abs_diff = (r_x > r_prev) ? (r_x - r_prev) : (r_prev - r_x);

    assign root_sat = (r_x > {{(NUM_W-ROOT_W){1'b0}}, {ROOT_W{1'b1}}}) ?
                      {ROOT_W{1'b1}} : r_x[ROOT_W-1:0];

    assign o_status.special = r_neg | r_zero;
    assign o_status.settled = (abs_diff <= {{(NUM_W-TOL_W){1'b0}}, r_tol}) || (r_x == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_num  <= rad_ext << FRAC_BITS;
            r_neg  <= i_radicand[RAD_W-1];
            r_zero <= (i_radicand == '0);
            r_x    <= seed_value(decade_count(rad_ext));
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= r_num;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NUM_W-2:0], q_bit};
        end
        if (i_cmd.step_x) begin
            r_prev <= r_x;
            r_x    <= n_x;
        end
        if (i_cmd.out_load) begin
            r_root    <= (r_neg | r_zero) ? '0 : root_sat;
            r_neg_out <= r_neg;
            r_hit_out <= i_cmd.out_hit;
        end
    end

    assign o_root           = r_root;
    assign o_negative_error = r_neg_out;
    assign o_hit_limit      = r_hit_out;

endmodule

FILE: rtl/sqrtn_ctrl.sv
// Controller: sequences load, divisions and Newton steps, and owns the result handshake.
module sqrtn_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output sqrtn_pkg::t_cmd    o_cmd,
    input  sqrtn_pkg::t_status i_status
);
    import sqrtn_pkg::*;

    t_state r_state, n_state;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic [STEP_CNT_W-1:0] r_steps;
    logic                  r_hit;
    logic                  r_out_valid;

    logic out_free, div_last, at_cap;

    assign out_free = ~r_out_valid | ~i_stall;
    assign div_last = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign at_cap   = (r_steps >= STEP_CNT_W'(MAX_ITERATIONS));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_START;
            S_START:  n_state = i_status.special ? S_FINISH : S_DIV;
            S_DIV:    if (div_last) n_state = S_STEP;
            S_STEP:   n_state = S_CHECK;
            S_CHECK: begin
                if (i_status.settled || at_cap) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_FINISH: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:   o_cmd.load_in  = i_valid;
            S_START:  o_cmd.div_init = ~i_status.special;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_STEP:   o_cmd.step_x   = 1'b1;
            S_CHECK:  o_cmd.div_init = ~i_status.settled & ~at_cap;
            S_FINISH: o_cmd.out_load = out_free;
            default:  o_cmd = '0;
        endcase
        o_cmd.out_hit = r_hit;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_cnt   <= '0;
            r_steps     <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_START: begin
                    r_div_cnt <= '0;
                    r_steps   <= '0;
                    r_hit     <= 1'b0;
                end
                S_DIV:   r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                S_STEP:  r_steps   <= r_steps + STEP_CNT_W'(1);
                S_CHECK: begin
                    r_div_cnt <= '0;
                    r_hit     <= ~i_status.settled;
                end
                default: ;
            endcase
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
